### hw/rtl/wbrc_pkg.sv
// Shared types and codes for the write-back record cache.
// No dependencies.
package wbrc_pkg;

    localparam int REC_W  = 31;
    localparam int DATA_W = 64;
    localparam int CFG_W  = 5;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_FILL  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    localparam logic [2:0] KIND_HIT   = 3'd0;
    localparam logic [2:0] KIND_FETCH = 3'd1;
    localparam logic [2:0] KIND_WB    = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    typedef struct packed {
        logic [1:0]        mode;
        logic [REC_W-1:0]  record_number;
        logic [DATA_W-1:0] data;
        logic [REC_W-1:0]  backing_count;
    } t_in;

    typedef struct packed {
        logic [2:0]        kind;
        logic [REC_W-1:0]  record_number_res;
        logic [DATA_W-1:0] data_res;
        logic [REC_W-1:0]  highest_written;
        logic              last;
    } t_out;

    typedef struct packed {
        t_in  item;
        logic rec_err;
    } t_cmd;

endpackage

### hw/rtl/wbrc_front.sv
// Front end: input register and request classification.
// Depends on wbrc_pkg.
module wbrc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  wbrc_pkg::t_in i_in_word,
    input  logic          i_q_full,
    output logic          o_push,
    output wbrc_pkg::t_cmd o_cmd
);
    import wbrc_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    assign o_in_stall = r_valid & i_q_full;
    assign o_push     = r_valid & ~i_q_full;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // record zero is an error for everything except flush
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd.item    <= i_in_word;
            r_cmd.rec_err <= (i_in_word.mode != MODE_FLUSH) &&
                             (i_in_word.record_number == '0);
        end
    end

endmodule

### hw/rtl/wbrc_queue.sv
// Two-word queue between front and back end.
// Depends on wbrc_pkg.
module wbrc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wbrc_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output wbrc_pkg::t_cmd o_cmd
);
    import wbrc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

### hw/rtl/wbrc_back.sv
// Back end: ordered entry store, lookup, eviction, flush walk, output register.
// Depends on wbrc_pkg.
module wbrc_back #(
    parameter int DEPTH       = 16,
    parameter int RECORD_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wbrc_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_q_valid,
    input  wbrc_pkg::t_cmd              i_q_cmd,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output wbrc_pkg::t_out              o_out_word
);
    import wbrc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SRCH   = 7'b0000010,
        S_ACT    = 7'b0000100,
        S_EVICT  = 7'b0001000,
        S_APPEND = 7'b0010000,
        S_DONE   = 7'b0100000,
        S_FLUSH  = 7'b1000000
    } t_state;

    // entries kept oldest first at position 0
    logic [REC_W-1:0]       r_tag [DEPTH];
    logic [RECORD_BITS-1:0] r_pay [DEPTH];
    logic                   r_dirty [DEPTH];

    t_state           r_state, n_state;
    t_cmd             r_cmd;
    logic             r_hit;
    logic             r_gap;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_occ;
    logic [CW-1:0]    r_cap;
    logic [REC_W-1:0] r_hs;
    logic             r_ov;
    t_out             r_out;

    logic             on, out_free, emit, fire;
    logic [2:0]       e_kind;
    logic [REC_W-1:0] e_rec;
    logic [DATA_W-1:0] e_data;
    logic             e_last;
    logic             do_rm, do_app;
    logic [CW-1:0]    rm_pos;
    logic [DEPTH-1:0] match;
    logic             s_hit;
    logic [CW-1:0]    s_pos;
    logic [REC_W-1:0] cnt;
    logic             s_gap;
    logic [REC_W-1:0]       rd_tag;
    logic [RECORD_BITS-1:0] rd_pay;
    logic                   rd_dirty;
    logic                   full;
    logic [CW-1:0]          cfg_sat;

    assign on       = (r_cap != '0);
    assign out_free = ~r_ov | ~i_out_stall;
    assign fire     = emit & out_free;
    assign rd_tag   = r_tag[r_idx[PW-1:0]];
    assign rd_pay   = r_pay[r_idx[PW-1:0]];
    assign rd_dirty = r_dirty[r_idx[PW-1:0]];
    assign full     = (r_occ == r_cap) && (r_occ != '0);
    assign cfg_sat  = ({1'b0, i_cfg_wdata} > (CFG_W+1)'(DEPTH)) ? CW'(DEPTH)
                                                               : CW'(i_cfg_wdata);

    always_comb begin
        s_hit = 1'b0;
        s_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (CW'(i) < r_occ) && (r_tag[i] == r_cmd.item.record_number);
            if (match[i]) begin
                s_hit = 1'b1;
                s_pos = CW'(i);
            end
        end
        cnt   = (on && r_hs > r_cmd.item.backing_count) ? r_hs
                                                         : r_cmd.item.backing_count;
        s_gap = {1'b0, r_cmd.item.record_number} > ({1'b0, cnt} + 32'd1);
    end

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        e_kind  = KIND_DONE;
        e_rec   = r_cmd.item.record_number;
        e_data  = '0;
        e_last  = 1'b1;
        do_rm   = 1'b0;
        do_app  = 1'b0;
        rm_pos  = '0;
        o_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: n_state = S_ACT;
            S_ACT: begin
                if (r_cmd.rec_err) begin
                    emit   = 1'b1;
                    e_kind = KIND_ERR;
                    e_rec  = '0;
                    if (fire) n_state = S_IDLE;
                end else begin
                    case (r_cmd.item.mode)
                        MODE_READ: begin
                            emit = 1'b1;
                            if (r_hit) begin
                                e_kind = KIND_HIT;
                                e_data = DATA_W'(rd_pay);
                            end else begin
                                e_kind = KIND_FETCH;
                            end
                            if (fire) n_state = S_IDLE;
                        end
                        MODE_FILL: n_state = (on && !r_hit) ? S_EVICT : S_DONE;
                        MODE_WRITE: begin
                            if (r_gap) begin
                                emit   = 1'b1;
                                e_kind = KIND_ERR;
                                if (fire) n_state = S_IDLE;
                            end else if (!on) begin
                                emit   = 1'b1;
                                e_kind = KIND_WB;
                                e_data = DATA_W'(r_cmd.item.data[RECORD_BITS-1:0]);
                                if (fire) n_state = S_IDLE;
                            end else begin
                                do_rm   = r_hit;
                                rm_pos  = r_idx;
                                n_state = S_EVICT;
                            end
                        end
                        default: n_state = on ? S_FLUSH : S_DONE;
                    endcase
                end
            end
            S_EVICT: begin
                if (full) begin
                    if (r_dirty[0]) begin
                        emit   = 1'b1;
                        e_kind = KIND_WB;
                        e_rec  = r_tag[0];
                        e_data = DATA_W'(r_pay[0]);
                        e_last = 1'b0;
                    end
                    if (!r_dirty[0] || fire) begin
                        do_rm   = 1'b1;
                        n_state = S_APPEND;
                    end
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                do_app  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                emit   = 1'b1;
                e_kind = KIND_DONE;
                if (r_cmd.item.mode == MODE_FLUSH) e_rec = '0;
                if (fire) n_state = S_IDLE;
            end
            S_FLUSH: begin
                if (r_idx < r_occ) begin
                    if (rd_dirty) begin
                        emit   = 1'b1;
                        e_kind = KIND_WB;
                        e_rec  = rd_tag;
                        e_data = DATA_W'(rd_pay);
                        e_last = 1'b0;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_cap   <= '0;
            r_hs    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire)           r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
            if (i_cfg_we && i_cfg_wdata != CFG_W'(1)) begin
                r_cap <= cfg_sat;
                r_occ <= '0;
                r_hs  <= '0;
            end else begin
                if (do_rm)  r_occ <= r_occ - CW'(1);
                if (do_app) r_occ <= r_occ + CW'(1);
                if (r_state == S_FLUSH && n_state == S_DONE) r_occ <= '0;
                if (r_state == S_ACT && do_rm == r_hit && r_cmd.item.mode == MODE_WRITE
                    && !r_cmd.rec_err && !r_gap && on
                    && r_cmd.item.record_number > r_hs)
                    r_hs <= r_cmd.item.record_number;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_q_cmd;
        if (r_state == S_SRCH) begin
            r_hit <= s_hit;
            r_gap <= s_gap;
            r_idx <= s_pos;
        end
        // a read keeps its hit position while the result waits
        if (r_state == S_ACT && r_cmd.item.mode != MODE_READ) r_idx <= '0;
        if (r_state == S_FLUSH && r_idx < r_occ && (!rd_dirty || fire))
            r_idx <= r_idx + CW'(1);
        if (fire) begin
            r_out.kind              <= e_kind;
            r_out.record_number_res <= e_rec;
            r_out.data_res          <= e_data;
            r_out.highest_written   <= r_hs;
            r_out.last              <= e_last;
        end
    end

    // shift toward oldest on removal, write newest at the fill level
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (do_rm && CW'(i) >= rm_pos && i < DEPTH - 1) begin
                r_tag[i]   <= r_tag[(i < DEPTH - 1) ? i + 1 : i];
                r_pay[i]   <= r_pay[(i < DEPTH - 1) ? i + 1 : i];
                r_dirty[i] <= r_dirty[(i < DEPTH - 1) ? i + 1 : i];
            end
            if (do_app && CW'(i) == r_occ) begin
                r_tag[i]   <= r_cmd.item.record_number;
                r_pay[i]   <= r_cmd.item.data[RECORD_BITS-1:0];
                r_dirty[i] <= (r_cmd.item.mode == MODE_WRITE);
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule

### hw/rtl/write_back_record_cache.sv
// Write-back record cache, top level.
// Requests are handled one at a time by the single back-end sequencer; the input
// register and the two-word queue take new requests while it is busy. A flush walks
// every cached entry, and output stalls hold the sequencer.
// Reset (i_rst_n low, synchronous): cache empty, capacity 0, highest written 0.
module write_back_record_cache #(
    parameter int DEPTH       = 16,
    parameter int RECORD_BITS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  wbrc_pkg::t_in              i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output wbrc_pkg::t_out             o_out_word,
    input  logic                       i_cfg_we,
    input  logic [wbrc_pkg::CFG_W-1:0] i_cfg_wdata
);
    import wbrc_pkg::*;

    logic q_full, push, pop, q_valid;
    t_cmd f_cmd, q_cmd;

    wbrc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_word (i_in_word),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (f_cmd)
    );

    wbrc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (f_cmd),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    wbrc_back #(
        .DEPTH      (DEPTH),
        .RECORD_BITS(RECORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

endmodule

### sim/write_back_record_cache_test.sv
// Testbench for write_back_record_cache: random and directed requests, checked
// against an in-bench model of the cache. Depends on wbrc_pkg and the RTL.
module write_back_record_cache_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wbrc_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in_word = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_word;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    write_back_record_cache #(.DEPTH(DEPTH), .RECORD_BITS(64)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // cache model: list of entries, oldest first
    int unsigned cap_m;
    logic [REC_W-1:0] tags_m[$];
    logic [DATA_W-1:0] pays_m[$];
    bit dirty_m[$];
    logic [REC_W-1:0] high_m;

    t_out pending_words[$];
    int mismatches = 0;
    int cycles = 0;
    bit idle_on = 1'b1;

    function automatic int find_tag(logic [REC_W-1:0] tag);
        for (int p = tags_m.size() - 1; p >= 0; p--)
            if (tags_m[p] == tag) return p;
        return -1;
    endfunction

    function automatic void push_word(ref t_out q[$], input logic [2:0] k,
                                      input logic [REC_W-1:0] r,
                                      input logic [DATA_W-1:0] d);
        t_out w;
        w = '0;
        w.kind = k;
        w.record_number_res = r;
        w.data_res = d;
        q.push_back(w);
    endfunction

    function automatic void insert_newest(ref t_out q[$], input logic [REC_W-1:0] tag,
                                          input logic [DATA_W-1:0] d, input bit dty);
        if (tags_m.size() >= cap_m && tags_m.size() > 0) begin
            if (dirty_m[0]) push_word(q, KIND_WB, tags_m[0], pays_m[0]);
            void'(tags_m.pop_front());
            void'(pays_m.pop_front());
            void'(dirty_m.pop_front());
        end
        tags_m.push_back(tag);
        pays_m.push_back(d);
        dirty_m.push_back(dty);
    endfunction

    function automatic void predict_request(t_in w);
        t_out q[$];
        logic [REC_W:0] known;
        bit on;
        int p;
        on = cap_m != 0;
        if (w.mode != MODE_FLUSH && w.record_number == 0) begin
            push_word(q, KIND_ERR, '0, '0);
        end else if (w.mode == MODE_READ) begin
            p = on ? find_tag(w.record_number) : -1;
            if (p >= 0) push_word(q, KIND_HIT, w.record_number, pays_m[p]);
            else push_word(q, KIND_FETCH, w.record_number, '0);
        end else if (w.mode == MODE_FILL) begin
            if (on && find_tag(w.record_number) < 0)
                insert_newest(q, w.record_number, w.data, 1'b0);
            push_word(q, KIND_DONE, w.record_number, '0);
        end else if (w.mode == MODE_WRITE) begin
            known = w.backing_count;
            if (on && high_m > known) known = high_m;
            if ({1'b0, w.record_number} > known + 1) begin
                push_word(q, KIND_ERR, w.record_number, '0);
            end else if (!on) begin
                push_word(q, KIND_WB, w.record_number, w.data);
            end else begin
                p = find_tag(w.record_number);
                if (p >= 0) begin
                    tags_m.delete(p);
                    pays_m.delete(p);
                    dirty_m.delete(p);
                end
                insert_newest(q, w.record_number, w.data, 1'b1);
                if (w.record_number > high_m) high_m = w.record_number;
                push_word(q, KIND_DONE, w.record_number, '0);
            end
        end else begin
            if (on) begin
                foreach (tags_m[i])
                    if (dirty_m[i]) push_word(q, KIND_WB, tags_m[i], pays_m[i]);
                tags_m.delete();
                pays_m.delete();
                dirty_m.delete();
            end
            push_word(q, KIND_DONE, '0, '0);
        end
        foreach (q[i]) begin
            q[i].highest_written = high_m;
            q[i].last = (i == q.size() - 1);
            pending_words.push_back(q[i]);
        end
    endfunction

    // result side: random stall, compare each accepted word
    always @(posedge i_clk) begin
        t_out want;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_out_word);
            end else begin
                want = pending_words.pop_front();
                if (o_out_word !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, o_out_word);
                end
            end
        end
        i_out_stall <= idle_on && ($urandom_range(99) < 23);
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid stays up after an accepted word until the next send or drain
    task automatic send_request(logic [1:0] mode, logic [REC_W-1:0] rec,
                                logic [DATA_W-1:0] d, logic [REC_W-1:0] backing);
        t_in w;
        w.mode = mode;
        w.record_number = rec;
        w.data = d;
        w.backing_count = backing;
        while (idle_on && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_word <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(w);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] v);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (v != 1) begin
            cap_m = v > DEPTH ? DEPTH : v;
            tags_m.delete();
            pays_m.delete();
            dirty_m.delete();
            high_m = '0;
        end
    endtask

    function automatic logic [DATA_W-1:0] rand_data();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_write_through();
        write_capacity(5'd0);
        send_request(MODE_READ, 31'd1, '0, '0);
        send_request(MODE_FILL, 31'd1, '1, '0);
        send_request(MODE_WRITE, 31'd1, '1, '0);
        send_request(MODE_WRITE, 31'd3, rand_data(), 31'd1);
        send_request(MODE_WRITE, '1, rand_data(), 31'h7FFF_FFFE);
        send_request(MODE_FLUSH, '0, '0, '0);
        send_request(MODE_READ, '0, '1, '1);
    endtask

    task automatic test_directed_cache();
        write_capacity(5'd1);   // refused, stays write-through
        send_request(MODE_WRITE, 31'd1, 64'h5, '0);
        write_capacity(5'd2);
        send_request(MODE_WRITE, 31'd1, 64'hA, '0);
        send_request(MODE_WRITE, 31'd2, 64'hB, '0);
        send_request(MODE_WRITE, 31'd4, 64'hC, '0);   // gap
        send_request(MODE_READ, 31'd1, '0, '0);
        send_request(MODE_FILL, 31'd2, 64'hF, '0);    // already cached
        send_request(MODE_FILL, 31'd7, '1, '0);       // evicts dirty
        send_request(MODE_WRITE, 31'd3, '1, '0);
        send_request(MODE_FLUSH, '1, '1, '1);
        send_request(MODE_FILL, '0, '0, '0);
        send_request(MODE_WRITE, '0, '0, '0);
        write_capacity(5'd31);  // saturates
        for (int i = 1; i <= 17; i++) send_request(MODE_WRITE, REC_W'(i), rand_data(), '0);
        send_request(MODE_FLUSH, '0, '0, '0);
    endtask

    task automatic test_random(int count);
        logic [1:0] m;
        logic [REC_W-1:0] r;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) idle_on = 1'b0;
            if (i == count / 2 + count / 4) idle_on = 1'b1;
            m = $urandom_range(99) < 8 ? MODE_FLUSH : 2'($urandom_range(2));
            r = $urandom_range(99) < 90 ? REC_W'($urandom_range(24)) : REC_W'($urandom());
            send_request(m, r, rand_data(),
                         $urandom_range(99) < 80 ? REC_W'($urandom_range(20))
                                                 : REC_W'($urandom()));
        end
    endtask

    initial begin
        cap_m = 0;
        high_m = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_write_through();
        test_directed_cache();
        write_capacity(5'd4);
        test_random(70);
        send_request(MODE_FLUSH, '0, '0, '0);
        write_capacity(5'd16);
        test_random(70);
        send_request(MODE_FLUSH, '0, '0, '0);
        write_capacity(5'd2);
        test_random(50);
        write_capacity(5'd0);
        test_random(20);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
